/* design/sirt_pkg.sv */
`default_nettype none
package sirt_pkg;

  localparam logic [5:0] DEFAULT_RADIX = 6'd10;
  localparam logic [5:0] MIN_RADIX     = 6'd2;
  localparam logic [5:0] MAX_RADIX     = 6'd36;
  localparam logic [6:0] MINUS_CHAR    = 7'h2D;
  localparam logic [6:0] ZERO_CHAR     = 7'h30;
  localparam logic [6:0] ALPHA_CHAR    = 7'h41;
  localparam logic [6:0] ERROR_CHAR    = 7'h00;
  localparam logic [5:0] NUM_DIGITS    = 6'd10;

  // divider commands from the sequencer
  typedef struct packed {
    logic load;   // take a new dividend
    logic start;  // run one division pass
  } div_ctl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic       done;     // one-cycle pulse, pass finished
    logic       quot_nz;  // quotient of that pass is nonzero
    logic [5:0] rem;      // remainder of that pass
  } div_sts_t;

  // digit value to ASCII; values past 'Z' map to '0'
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < NUM_DIGITS) begin
      c = ZERO_CHAR + {1'b0, d};
    end else if (d < MAX_RADIX) begin
      c = ALPHA_CHAR + {1'b0, d - NUM_DIGITS};
    end else begin
      c = ZERO_CHAR;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/sirt_div.sv */
`default_nettype none
// Bit-serial restoring divider: one quotient bit per cycle.
// The quotient replaces the dividend in place, so passes can be chained.
module sirt_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sirt_pkg::div_ctl_t      ctl,
  input  logic [VALUE_BITS-1:0]   load_mag,
  input  logic [5:0]              radix,
  output sirt_pkg::div_sts_t      sts
);
  import sirt_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [5:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  qnz_r, qnz_nxt;
  logic                  done_r, done_nxt;

  logic [6:0] trial;
  logic [6:0] diff;
  logic       ge;

  assign trial = {rem_r, mag_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, radix};
  assign ge    = (trial >= {1'b0, radix});

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    qnz_nxt  = qnz_r;
    done_nxt = 1'b0;
    if (ctl.load) begin
      mag_nxt = load_mag;
    end
    if (ctl.start) begin
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
      qnz_nxt  = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[5:0] : trial[5:0];
      mag_nxt = {mag_r[VALUE_BITS-2:0], ge};
      qnz_nxt = qnz_r | ge;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    qnz_r <= qnz_nxt;
  end

  assign sts.done    = done_r;
  assign sts.quot_nz = qnz_r;
  assign sts.rem     = rem_r;

endmodule
`default_nettype wire

/* design/signed_integer_to_radix_text_unit.sv */
`default_nettype none
// Signed integer to ASCII text in radix 2..36.
// Input channel (in_valid / in_stall): one transfer carries in_value, in_radix
// and in_radix_given; with in_radix_given low the radix is ten.
// Output channel (out_valid / out_stall): one transfer per character, most
// significant first, a leading '-' for negative values, out_last on the final
// character. A radix outside 2..36 yields one transfer with char_code 0,
// out_last and out_radix_error set.
// Sequence: each digit costs one division pass in the bit-serial divider; each
// character then goes through the digit memory read and the output register,
// the minus sign through the output register alone. The worst case is the most
// negative value in base two, which has the most digits and a sign.
// One item is in flight at a time; in_stall stays high from acceptance until the
// last character is loaded into the output register and while a stalled
// character waits there, so the next transfer can coincide with the final one.
// Out_stall holds the output register; the sequencer simply waits.
// Reset (synchronous, rst_n low) returns to idle with no pending output;
// the digit memory is not cleared since every conversion writes before reading.
module signed_integer_to_radix_text_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [5:0]                   in_radix,
  input  logic                         in_radix_given,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [6:0]                   out_char_code,
  output logic                         out_last,
  output logic                         out_radix_error
);
  import sirt_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);  // digit count, can reach VALUE_BITS
  localparam int AW = $clog2(VALUE_BITS);      // digit memory address

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an input transfer
    S_DIV  = 5'b00010,  // division passes, one digit each
    S_SIGN = 5'b00100,  // put the minus sign
    S_READ = 5'b01000,  // read the next digit from memory
    S_CHAR = 5'b10000   // put the digit character
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            neg_r, neg_nxt;
  logic [5:0]      radix_r, radix_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [6:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_err_r, out_err_nxt;

  // digit store, least significant digit at address 0
  logic [5:0]      digit_store_r [VALUE_BITS];
  logic [5:0]      rd_data_r;
  logic            st_we;
  logic            rd_en;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_dec;

  div_ctl_t        div_ctl;
  div_sts_t        div_sts;

  logic [VALUE_BITS-1:0] val_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic [5:0]            radix_eff;
  logic                  radix_bad;
  logic                  out_free;
  logic                  in_take;

  assign val_u     = in_value;
  assign mag_in    = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;
  assign radix_eff = in_radix_given ? in_radix : DEFAULT_RADIX;
  assign radix_bad = (radix_eff < MIN_RADIX) || (radix_eff > MAX_RADIX);

  // output register can take a new character this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_take   = in_valid && !in_stall;
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    neg_nxt       = neg_r;
    radix_nxt     = radix_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    div_ctl       = '0;
    st_we         = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          count_nxt = '0;
          if (radix_bad) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = ERROR_CHAR;
            out_last_nxt  = 1'b1;
            out_err_nxt   = 1'b1;
          end else begin
            div_ctl.load  = 1'b1;
            div_ctl.start = 1'b1;
            neg_nxt       = val_u[VALUE_BITS-1];
            radix_nxt     = radix_eff;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          st_we     = 1'b1;
          count_nxt = count_inc;
          // keep dividing while the quotient is nonzero and the store has room
          if (div_sts.quot_nz && (count_inc != CW'(VALUE_BITS))) begin
            div_ctl.start = 1'b1;
          end else begin
            state_nxt = neg_r ? S_SIGN : S_READ;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_CHAR;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CHAR;
      end
      S_CHAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r);
          out_last_nxt  = (count_r == CW'(1));
          out_err_nxt   = 1'b0;
          count_nxt     = count_dec;
          state_nxt     = (count_r == CW'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // digit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      digit_store_r[count_r[AW-1:0]] <= div_sts.rem;
    end
    if (rd_en) begin
      rd_data_r <= digit_store_r[count_dec[AW-1:0]];
    end
  end

  sirt_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .load_mag (mag_in),
    .radix    (radix_r),
    .sts      (div_sts)
  );

  assign out_valid       = out_valid_r;
  assign out_char_code   = out_char_r;
  assign out_last        = out_last_r;
  assign out_radix_error = out_err_r;

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  import sirt_pkg::*;

  localparam int VB           = 32;       // width of in_value
  localparam int CASES        = 25;       // rows in the directed table
  localparam int RANDOM_ITEMS = 305;
  localparam int HOLD_AT      = 60;       // random item that starts the long receiver hold
  localparam int PAUSE_AT     = 200;      // random item before which the sender drains
  localparam int LONG_HOLD    = 3000;     // cycles, well past one worst-case conversion
  localparam int DRAIN_CYCLES = 2500;     // quiet time at the end, about two conversions
  localparam int CYCLE_LIMIT  = 4000000;

  // kind of directed row: check against the predictor, against typed-in
  // text, or expect the single bad-radix transfer
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_ERROR} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [VB-1:0]  value;
    logic [5:0]     radix;
    logic           given;
  } conv_row_t;

  // one character transfer on the result channel
  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
    logic       radix_error;
  } char_xfer_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VB-1:0] in_value = '0;
  logic [5:0]    in_radix = '0;
  logic          in_radix_given = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [6:0]    out_char_code;
  logic          out_last;
  logic          out_radix_error;

  char_xfer_t expected_chars[$];   // characters still owed by the block, oldest first
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         in_idle_pct = 0;     // chance per cycle that the sender holds back
  int         out_stall_pct = 0;   // chance per cycle that the receiver stalls
  int         hold_requests = 0;   // bumped by the stimulus to ask for a long hold
  int         hold_served = 0;
  int         hold_left = 0;

  // Directed table: extremes of the value, both radix defaults, each bad-radix
  // band, zero in two bases, the most negative value in several bases.
  conv_row_t conversion_cases [CASES] = '{
    '{ROW_TEXT,    32'h0000_0000, 6'd0,  1'b0},
    '{ROW_TEXT,    32'h0000_0000, 6'd2,  1'b1},
    '{ROW_TEXT,    32'h7FFF_FFFF, 6'd10, 1'b0},
    '{ROW_TEXT,    32'h8000_0000, 6'd0,  1'b0},
    '{ROW_PREDICT, 32'h8000_0000, 6'd2,  1'b1},
    '{ROW_PREDICT, 32'h7FFF_FFFF, 6'd36, 1'b1},
    '{ROW_TEXT,    32'hFFFF_FFFF, 6'd10, 1'b1},
    '{ROW_TEXT,    32'h0000_0001, 6'd2,  1'b1},
    '{ROW_ERROR,   32'h0000_0005, 6'd0,  1'b1},
    '{ROW_ERROR,   32'h8000_0000, 6'd1,  1'b1},
    '{ROW_ERROR,   32'h7FFF_FFFF, 6'd37, 1'b1},
    '{ROW_ERROR,   32'h0000_0000, 6'd63, 1'b1},
    '{ROW_TEXT,    32'd123,       6'd0,  1'b0},
    '{ROW_TEXT,    32'hFFFF_FFD3, 6'd63, 1'b0},
    '{ROW_TEXT,    32'd35,        6'd36, 1'b1},
    '{ROW_TEXT,    32'd255,       6'd16, 1'b1},
    '{ROW_TEXT,    32'hFFFF_FFFF, 6'd16, 1'b1},
    '{ROW_PREDICT, 32'h7FFF_FFFF, 6'd2,  1'b1},
    '{ROW_PREDICT, 32'h8000_0000, 6'd36, 1'b1},
    '{ROW_PREDICT, 32'h8000_0001, 6'd3,  1'b1},
    '{ROW_TEXT,    32'd10,        6'd10, 1'b1},
    '{ROW_TEXT,    32'hFFFF_FFFE, 6'd2,  1'b1},
    '{ROW_PREDICT, 32'h5555_5555, 6'd2,  1'b1},
    '{ROW_PREDICT, 32'hAAAA_AAAA, 6'd16, 1'b1},
    '{ROW_TEXT,    32'd1295,      6'd36, 1'b1}
  };

  // text typed in from the rows above; empty where the predictor decides
  string case_text [CASES] = '{
    "0", "0", "2147483647", "-2147483648", "", "", "-1", "1",
    "", "", "", "", "123", "-45", "Z", "FF", "-1", "", "", "",
    "10", "-10", "", "", "ZZ"
  };

  signed_integer_to_radix_text_unit #(
    .VALUE_BITS(VB)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_radix_given (in_radix_given),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_radix_error(out_radix_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Conversion predictor: radix select, bad-radix check, unsigned magnitude,
  // digits by repeated division (lsd first), then '-' and digits msd first.
  function automatic void predict_conversion(input logic [VB-1:0] value,
                                             input logic [5:0] radix_in,
                                             input logic given);
    logic [31:0] base;
    logic [31:0] mag;
    logic [5:0]  digits [VB];
    logic [6:0]  ch;
    logic        neg;
    int          n;
    base = given ? {26'd0, radix_in} : {26'd0, DEFAULT_RADIX};
    if (base < MIN_RADIX || base > MAX_RADIX) begin
      expected_chars.push_back(char_xfer_t'{ERROR_CHAR, 1'b1, 1'b1});
      return;
    end
    neg = value[VB-1];
    // two's complement negate; the most negative value stays 2^31 unsigned
    mag = neg ? (~value + 32'd1) : value;
    n = 0;
    do begin
      digits[n] = 6'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0 && n < VB);
    if (neg) begin
      expected_chars.push_back(char_xfer_t'{MINUS_CHAR, 1'b0, 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (digits[i] < 6'd10) begin
        ch = ZERO_CHAR + {1'b0, digits[i]};
      end else begin
        ch = ALPHA_CHAR + {1'b0, digits[i] - 6'd10};
      end
      expected_chars.push_back(char_xfer_t'{ch, i == 0, 1'b0});
    end
  endfunction

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end  // no idling at all
      1: begin in_idle_pct = 56; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 56; end
      default: begin in_idle_pct = 17; out_stall_pct = 17; end
    endcase
  endtask

  // Offer one item; called at a falling edge, returns at a falling edge.
  // Expectations are queued at the edge where the transfer happens.
  task automatic send_item(input logic [VB-1:0] value, input logic [5:0] radix,
                           input logic given, input row_kind_t kind, input string text);
    byte b;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_radix       <= radix;
    in_radix_given <= given;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (kind)
      ROW_TEXT: begin
        for (int k = 0; k < text.len(); k++) begin
          b = text[k];
          expected_chars.push_back(char_xfer_t'{b[6:0], k == text.len() - 1, 1'b0});
        end
      end
      ROW_ERROR: expected_chars.push_back(char_xfer_t'{ERROR_CHAR, 1'b1, 1'b1});
      default:   predict_conversion(value, radix, given);
    endcase
    @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold counted here once requested.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Result checker: every character transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transfer: char_code %0h last %0b radix_error %0b",
               out_char_code, out_last, out_radix_error);
        mismatch_count++;
      end else begin
        if (out_char_code !== expected_chars[0].char_code) begin
          $error("char_code: expected %0h, actual %0h",
                 expected_chars[0].char_code, out_char_code);
          mismatch_count++;
        end
        if (out_last !== expected_chars[0].last) begin
          $error("last: expected %0b, actual %0b", expected_chars[0].last, out_last);
          mismatch_count++;
        end
        if (out_radix_error !== expected_chars[0].radix_error) begin
          $error("radix_error: expected %0b, actual %0b",
                 expected_chars[0].radix_error, out_radix_error);
          mismatch_count++;
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [VB-1:0] value;
    logic [5:0]    radix;
    logic          given;
    int            sel;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, idling phase rotated per row
    for (int r = 0; r < CASES; r++) begin
      set_phase(r);
      send_item(conversion_cases[r].value, conversion_cases[r].radix,
                conversion_cases[r].given, conversion_cases[r].kind, case_text[r]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      set_phase(i / 25);
      if (i == HOLD_AT) begin
        hold_requests++;   // receiver sits still; input backs up behind it
      end
      if (i == PAUSE_AT) begin
        // sender waits for the block to empty completely
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_chars.size() != 0) @(negedge clk);
      end

      // value: mostly random magnitudes of random width, some full-width, some extremes
      sel = $urandom_range(9);
      case (sel)
        0: begin
          case ($urandom_range(4))
            0: value = 32'h0000_0000;
            1: value = 32'h0000_0001;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h8000_0000;
            default: value = 32'h7FFF_FFFF;
          endcase
        end
        1, 2, 3: value = $urandom;
        default: begin
          value = $urandom >> $urandom_range(31);
          if ($urandom_range(1) == 1) value = ~value + 32'd1;
        end
      endcase

      // radix: mostly a valid given radix, some default, a few out of range
      sel = $urandom_range(99);
      if (sel < 8) begin
        given = 1'b1;
        radix = ($urandom_range(1) == 1) ? 6'($urandom_range(1)) : 6'($urandom_range(37, 63));
      end else if (sel < 25) begin
        given = 1'b0;
        radix = 6'($urandom_range(63));   // ignored by the block
      end else begin
        given = 1'b1;
        radix = 6'($urandom_range(2, 36));
      end

      send_item(value, radix, given, ROW_PREDICT, "");
    end

    in_valid <= 1'b0;
    set_phase(0);
    while (expected_chars.size() != 0) @(negedge clk);
    // stay a while longer to catch any stray transfer
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
design/sirt_pkg.sv
design/sirt_div.sv
design/signed_integer_to_radix_text_unit.sv
dv/tb.sv
